>>> design/tdg_pkg.sv
`timescale 1ns / 1ps
// tdg_pkg: shared constants and types of the touch drag gesture detector
// no dependencies; used by every module of the block

package tdg_pkg;

  // field widths that do not follow the coordinate width
  localparam int CMD_W      = 3;
  localparam int CNT_W      = 4;
  localparam int PH_W       = 3;
  localparam int THRESH_W   = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int LIM_W      = THRESH_W + 1;
  localparam int LIM_SQ_W   = 2 * LIM_W;

  // event kinds
  localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PDOWN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUP    = 3'd4;

  // gesture phases
  localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PH_W-1:0] PH_MAYBE    = 3'd1;
  localparam logic [PH_W-1:0] PH_STARTED  = 3'd2;
  localparam logic [PH_W-1:0] PH_UPDATED  = 3'd3;
  localparam logic [PH_W-1:0] PH_FINISHED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd1;

  // threshold reset and the matching squared limit (threshold + 1)^2
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd16;
  localparam logic [LIM_SQ_W-1:0] LIM_SQ_RESET =
    LIM_SQ_W'((int'(THRESH_RESET) + 1) * (int'(THRESH_RESET) + 1));

  // live configuration seen by the gesture logic
  typedef struct packed {
    logic                ignore_mode;
    logic [LIM_SQ_W-1:0] lim_sq;
  } cfg_t;

endpackage

>>> design/tdg_dist.sv
`timescale 1ns / 1ps
// tdg_dist: squared distance test of a move against the drag origin
// depends on tdg_pkg

module tdg_dist #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        org_x_i,
  input  logic [COORD_BITS-1:0]        org_y_i,
  input  logic [COORD_BITS-1:0]        pt_x_i,
  input  logic [COORD_BITS-1:0]        pt_y_i,
  input  logic [tdg_pkg::LIM_SQ_W-1:0] lim_sq_i,
  output logic                         far_o
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = (SQ_W + 1 > tdg_pkg::LIM_SQ_W) ? SQ_W + 1 : tdg_pkg::LIM_SQ_W;

  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       dx_sq, dy_sq;
  logic [SUM_W-1:0]      dist_sq;

  // absolute differences
  assign dx = (org_x_i > pt_x_i) ? (org_x_i - pt_x_i) : (pt_x_i - org_x_i);
  assign dy = (org_y_i > pt_y_i) ? (org_y_i - pt_y_i) : (pt_y_i - org_y_i);

  // two parallel squarings, then add and compare
  assign dx_sq   = SQ_W'(dx) * SQ_W'(dx);
  assign dy_sq   = SQ_W'(dy) * SQ_W'(dy);
  assign dist_sq = SUM_W'(dx_sq) + SUM_W'(dy_sq);
  assign far_o   = (dist_sq >= SUM_W'(lim_sq_i));

endmodule

>>> design/tdg_core.sv
`timescale 1ns / 1ps
// tdg_core: gesture phase, stored positions and trigger flag, one event per step
// depends on tdg_pkg and tdg_dist

module tdg_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  tdg_pkg::cfg_t               cfg_i,
  input  logic [tdg_pkg::CMD_W-1:0]   cmd_i,
  input  logic [tdg_pkg::CNT_W-1:0]   touch_count_i,
  input  logic [tdg_pkg::CNT_W-1:0]   pressed_count_i,
  input  logic [COORD_BITS-1:0]       first_x_i,
  input  logic [COORD_BITS-1:0]       first_y_i,
  input  logic [COORD_BITS-1:0]       pressed_x_i,
  input  logic [COORD_BITS-1:0]       pressed_y_i,
  input  logic                        inside_region_i,
  output logic                        trigger_o,
  output logic [tdg_pkg::PH_W-1:0]    phase_o,
  output logic [COORD_BITS-1:0]       org_x_o,
  output logic [COORD_BITS-1:0]       org_y_o,
  output logic [COORD_BITS-1:0]       prv_x_o,
  output logic [COORD_BITS-1:0]       prv_y_o,
  output logic [COORD_BITS-1:0]       cur_x_o,
  output logic [COORD_BITS-1:0]       cur_y_o
);

  logic                     trig_q, trig_d;
  logic [tdg_pkg::PH_W-1:0] ph_q, ph_d;
  logic [COORD_BITS-1:0]    org_x_q, org_x_d, org_y_q, org_y_d;
  logic [COORD_BITS-1:0]    prv_x_q, prv_x_d, prv_y_q, prv_y_d;
  logic [COORD_BITS-1:0]    cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                     active, maybe, far;

  assign active = (ph_q == tdg_pkg::PH_STARTED) || (ph_q == tdg_pkg::PH_UPDATED);
  assign maybe  = (ph_q == tdg_pkg::PH_MAYBE);

  // distance of the first point from the origin
  tdg_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .org_x_i (org_x_q),
    .org_y_i (org_y_q),
    .pt_x_i  (first_x_i),
    .pt_y_i  (first_y_i),
    .lim_sq_i(cfg_i.lim_sq),
    .far_o   (far)
  );

  // next gesture state, checks in priority order
  always_comb begin
    trig_d  = 1'b0;
    ph_d    = ph_q;
    org_x_d = org_x_q;
    org_y_d = org_y_q;
    prv_x_d = prv_x_q;
    prv_y_d = prv_y_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    priority if (cfg_i.ignore_mode || (touch_count_i == '0)) begin
      // forced finish with positions kept; a pending gesture goes idle and clears
      if (active) begin
        ph_d   = tdg_pkg::PH_FINISHED;
        trig_d = 1'b1;
      end else if (maybe) begin
        ph_d    = tdg_pkg::PH_IDLE;
        org_x_d = '0;
        org_y_d = '0;
        prv_x_d = '0;
        prv_y_d = '0;
        cur_x_d = '0;
        cur_y_d = '0;
      end
    end else if (!inside_region_i || (cmd_i == tdg_pkg::CMD_UP) ||
                 (cmd_i == tdg_pkg::CMD_PDOWN)) begin
      // finish at the first point; a pending gesture goes idle and clears
      if (active) begin
        prv_x_d = cur_x_q;
        prv_y_d = cur_y_q;
        cur_x_d = first_x_i;
        cur_y_d = first_y_i;
        ph_d    = tdg_pkg::PH_FINISHED;
        trig_d  = 1'b1;
      end else if (maybe) begin
        ph_d    = tdg_pkg::PH_IDLE;
        org_x_d = '0;
        org_y_d = '0;
        prv_x_d = '0;
        prv_y_d = '0;
        cur_x_d = '0;
        cur_y_d = '0;
      end
    end else if (cmd_i == tdg_pkg::CMD_DOWN) begin
      // single finger down arms the gesture
      if (touch_count_i == tdg_pkg::CNT_W'(1)) begin
        org_x_d = first_x_i;
        org_y_d = first_y_i;
        prv_x_d = first_x_i;
        prv_y_d = first_y_i;
        cur_x_d = first_x_i;
        cur_y_d = first_y_i;
        ph_d    = tdg_pkg::PH_MAYBE;
        trig_d  = 1'b1;
      end
    end else if (cmd_i == tdg_pkg::CMD_PUP) begin
      // back to one pressed finger re-arms at it
      if (pressed_count_i == tdg_pkg::CNT_W'(1)) begin
        org_x_d = pressed_x_i;
        org_y_d = pressed_y_i;
        prv_x_d = pressed_x_i;
        prv_y_d = pressed_y_i;
        cur_x_d = pressed_x_i;
        cur_y_d = pressed_y_i;
        ph_d    = tdg_pkg::PH_MAYBE;
      end
    end else if (cmd_i == tdg_pkg::CMD_MOVE) begin
      // move starts or updates the drag
      if (touch_count_i == tdg_pkg::CNT_W'(1)) begin
        if ((maybe && far) || active) begin
          prv_x_d = cur_x_q;
          prv_y_d = cur_y_q;
          cur_x_d = first_x_i;
          cur_y_d = first_y_i;
          ph_d    = maybe ? tdg_pkg::PH_STARTED : tdg_pkg::PH_UPDATED;
          trig_d  = 1'b1;
        end
      end
    end else begin
      // other event kinds leave everything as it is
    end
  end

  // state registers double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q  <= 1'b0;
      ph_q    <= tdg_pkg::PH_IDLE;
      org_x_q <= '0;
      org_y_q <= '0;
      prv_x_q <= '0;
      prv_y_q <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else if (step_i) begin
      trig_q  <= trig_d;
      ph_q    <= ph_d;
      org_x_q <= org_x_d;
      org_y_q <= org_y_d;
      prv_x_q <= prv_x_d;
      prv_y_q <= prv_y_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

  assign trigger_o = trig_q;
  assign phase_o   = ph_q;
  assign org_x_o   = org_x_q;
  assign org_y_o   = org_y_q;
  assign prv_x_o   = prv_x_q;
  assign prv_y_o   = prv_y_q;
  assign cur_x_o   = cur_x_q;
  assign cur_y_o   = cur_y_q;

endmodule

>>> design/touch_drag_gesture_fsm.sv
`timescale 1ns / 1ps
// touch_drag_gesture_fsm: top level with input register, result handshake and config
// depends on tdg_pkg, tdg_core and tdg_dist

// Single-finger drag detector. One touch event is taken per clock cycle unless
// the input is stalled, and every event yields exactly one result: a trigger flag,
// the gesture phase and the start, previous and current positions after the event.
// An event sits in the input register and is evaluated in one step (two squarings,
// an add and a compare against the registered (threshold + 1)^2) into the state
// registers, which are the result register and load once the result slot is free.
// A stalled result holds the next event in the input register, which stalls the
// input in the same cycle. Configuration is written through a plain write port;
// the user writes it only while the block is idle, which the block does not enforce.

module touch_drag_gesture_fsm #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // touch event channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tdg_pkg::CMD_W-1:0]      cmd_i,
  input  logic [tdg_pkg::CNT_W-1:0]      touch_count_i,
  input  logic [tdg_pkg::CNT_W-1:0]      pressed_count_i,
  input  logic [COORD_BITS-1:0]          first_x_i,
  input  logic [COORD_BITS-1:0]          first_y_i,
  input  logic [COORD_BITS-1:0]          pressed_x_i,
  input  logic [COORD_BITS-1:0]          pressed_y_i,
  input  logic                           inside_region_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           trigger_o,
  output logic [tdg_pkg::PH_W-1:0]       drag_phase_o,
  output logic [COORD_BITS-1:0]          start_x_o,
  output logic [COORD_BITS-1:0]          start_y_o,
  output logic [COORD_BITS-1:0]          prev_x_o,
  output logic [COORD_BITS-1:0]          prev_y_o,
  output logic [COORD_BITS-1:0]          cur_x_o,
  output logic [COORD_BITS-1:0]          cur_y_o
);

  logic                          in_valid_q;
  logic [tdg_pkg::CMD_W-1:0]     cmd_q;
  logic [tdg_pkg::CNT_W-1:0]     tcnt_q, pcnt_q;
  logic [COORD_BITS-1:0]         fx_q, fy_q, px_q, py_q;
  logic                          inside_q;
  logic                          out_valid_q, out_valid_d;
  logic                          in_load, step;
  tdg_pkg::cfg_t                 cfg_q;
  logic [tdg_pkg::LIM_W-1:0]     lim;

  // handshake: evaluate when the result slot is free or being taken
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_load    = in_valid_i && !in_stall_o;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q    <= cmd_i;
      tcnt_q   <= touch_count_i;
      pcnt_q   <= pressed_count_i;
      fx_q     <= first_x_i;
      fy_q     <= first_y_i;
      px_q     <= pressed_x_i;
      py_q     <= pressed_y_i;
      inside_q <= inside_region_i;
    end
  end

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers, threshold kept as its squared limit
  assign lim = tdg_pkg::LIM_W'(cfg_wdata_i) + tdg_pkg::LIM_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_mode <= 1'b0;
      cfg_q.lim_sq      <= tdg_pkg::LIM_SQ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdg_pkg::CFG_IGNORE_MODE: cfg_q.ignore_mode <= cfg_wdata_i[0];
        tdg_pkg::CFG_THRESHOLD:   cfg_q.lim_sq <= tdg_pkg::LIM_SQ_W'(lim) *
                                                  tdg_pkg::LIM_SQ_W'(lim);
        default: ;
      endcase
    end
  end

  // gesture evaluation and state
  tdg_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd_q),
    .touch_count_i  (tcnt_q),
    .pressed_count_i(pcnt_q),
    .first_x_i      (fx_q),
    .first_y_i      (fy_q),
    .pressed_x_i    (px_q),
    .pressed_y_i    (py_q),
    .inside_region_i(inside_q),
    .trigger_o      (trigger_o),
    .phase_o        (drag_phase_o),
    .org_x_o        (start_x_o),
    .org_y_o        (start_y_o),
    .prv_x_o        (prev_x_o),
    .prv_y_o        (prev_y_o),
    .cur_x_o        (cur_x_o),
    .cur_y_o        (cur_y_o)
  );

  assign out_valid_o = out_valid_q;

  // checks
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("evaluated event produced no result");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled without a pending event");

  a_trigger_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_o |-> drag_phase_o != tdg_pkg::PH_IDLE)
    else $error("trigger reported in idle phase");

  a_idle_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drag_phase_o == tdg_pkg::PH_IDLE |->
      start_x_o == '0 && start_y_o == '0 && prev_x_o == '0 &&
      prev_y_o == '0 && cur_x_o == '0 && cur_y_o == '0)
    else $error("idle phase with nonzero positions");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the touch drag gesture detector
// depends on tdg_pkg and touch_drag_gesture_fsm, and through it on tdg_core and tdg_dist

module tb_top;

  localparam int COORD_W     = 12;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int TAIL_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;

  // event kind with no action of its own
  localparam logic [tdg_pkg::CMD_W-1:0] CMD_OTHER = 3'd5;

  // receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_RUNS  = 3;

  typedef struct packed {
    logic [tdg_pkg::CMD_W-1:0] cmd;
    logic [tdg_pkg::CNT_W-1:0] touches;
    logic [tdg_pkg::CNT_W-1:0] pressed;
    logic [COORD_W-1:0]        fx, fy, px, py;
    logic                      in_region;
  } touch_evt_t;

  typedef struct packed {
    logic                     trig;
    logic [tdg_pkg::PH_W-1:0] phase;
    logic [COORD_W-1:0]       sx, sy, prx, pry, cx, cy;
  } gesture_res_t;

  // dut connections
  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [tdg_pkg::CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [tdg_pkg::CMD_W-1:0]      cmd_i           = '0;
  logic [tdg_pkg::CNT_W-1:0]      touch_count_i   = '0;
  logic [tdg_pkg::CNT_W-1:0]      pressed_count_i = '0;
  logic [COORD_W-1:0]             first_x_i       = '0;
  logic [COORD_W-1:0]             first_y_i       = '0;
  logic [COORD_W-1:0]             pressed_x_i     = '0;
  logic [COORD_W-1:0]             pressed_y_i     = '0;
  logic                           inside_region_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic                           trigger_o;
  logic [tdg_pkg::PH_W-1:0]       drag_phase_o;
  logic [COORD_W-1:0]  start_x_o, start_y_o, prev_x_o, prev_y_o, cur_x_o, cur_y_o;

  // gesture tracker state and its configuration copy
  logic                         ign_mode = 1'b0;
  logic [tdg_pkg::THRESH_W-1:0] thresh   = tdg_pkg::THRESH_RESET;
  logic [tdg_pkg::PH_W-1:0]     gphase   = tdg_pkg::PH_IDLE;
  logic [COORD_W-1:0]  org_x = '0, org_y = '0, last_x = '0, last_y = '0;
  logic [COORD_W-1:0]  now_x = '0, now_y = '0;

  touch_evt_t   evt_queue[$];
  gesture_res_t expected_res[$];
  touch_evt_t   on_wire;
  int           n_queued = 0;
  int           n_errors = 0;

  touch_drag_gesture_fsm #(
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .touch_count_i  (touch_count_i),
    .pressed_count_i(pressed_count_i),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .pressed_x_i    (pressed_x_i),
    .pressed_y_i    (pressed_y_i),
    .inside_region_i(inside_region_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_o      (trigger_o),
    .drag_phase_o   (drag_phase_o),
    .start_x_o      (start_x_o),
    .start_y_o      (start_y_o),
    .prev_x_o       (prev_x_o),
    .prev_y_o       (prev_y_o),
    .cur_x_o        (cur_x_o),
    .cur_y_o        (cur_y_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // gesture tracker helpers
  task automatic clear_drag();
    gphase = tdg_pkg::PH_IDLE;
    org_x = '0; org_y = '0; last_x = '0; last_y = '0; now_x = '0; now_y = '0;
  endtask

  task automatic arm_drag(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    org_x = x; org_y = y; last_x = x; last_y = y; now_x = x; now_y = y;
    gphase = tdg_pkg::PH_MAYBE;
  endtask

  task automatic shift_to(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    last_x = now_x; last_y = now_y;
    now_x = x; now_y = y;
  endtask

  // advance the tracker by one event and form the result it reports
  task automatic drag_step(input touch_evt_t ev, output gesture_res_t r);
    logic        active;
    logic        trig;
    int unsigned dx, dy, lim;
    active = (gphase == tdg_pkg::PH_STARTED) || (gphase == tdg_pkg::PH_UPDATED);
    trig   = 1'b0;
    if (ign_mode || ev.touches == 0) begin
      // finish keeps positions; a pending gesture goes idle and clears
      if (active) begin
        gphase = tdg_pkg::PH_FINISHED;
        trig   = 1'b1;
      end else if (gphase == tdg_pkg::PH_MAYBE) begin
        clear_drag();
      end
    end else if (!ev.in_region || ev.cmd == tdg_pkg::CMD_UP ||
                 ev.cmd == tdg_pkg::CMD_PDOWN) begin
      // finish moves to the first point; a pending gesture goes idle and clears
      if (active) begin
        shift_to(ev.fx, ev.fy);
        gphase = tdg_pkg::PH_FINISHED;
        trig   = 1'b1;
      end else if (gphase == tdg_pkg::PH_MAYBE) begin
        clear_drag();
      end
    end else if (ev.cmd == tdg_pkg::CMD_DOWN) begin
      if (ev.touches == 1) begin
        arm_drag(ev.fx, ev.fy);
        trig = 1'b1;
      end
    end else if (ev.cmd == tdg_pkg::CMD_PUP) begin
      if (ev.pressed == 1) arm_drag(ev.px, ev.py);
    end else if (ev.cmd == tdg_pkg::CMD_MOVE && ev.touches == 1) begin
      if (gphase == tdg_pkg::PH_MAYBE) begin
        dx  = (org_x > ev.fx) ? org_x - ev.fx : ev.fx - org_x;
        dy  = (org_y > ev.fy) ? org_y - ev.fy : ev.fy - org_y;
        lim = thresh + 1;
        if (dx * dx + dy * dy >= lim * lim) begin
          shift_to(ev.fx, ev.fy);
          gphase = tdg_pkg::PH_STARTED;
          trig   = 1'b1;
        end
      end else if (active) begin
        shift_to(ev.fx, ev.fy);
        gphase = tdg_pkg::PH_UPDATED;
        trig   = 1'b1;
      end
    end
    r = '{trig: trig, phase: gphase, sx: org_x, sy: org_y, prx: last_x, pry: last_y,
          cx: now_x, cy: now_y};
  endtask

  // driver: bursts of transfers with random gaps
  int burst_left, gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    gesture_res_t pred;
    touch_evt_t   nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        drag_step(on_wire, pred);
        expected_res.push_back(pred);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (evt_queue.size() > 0) begin
          nxt     = evt_queue.pop_front();
          on_wire = nxt;
          cmd_i           <= nxt.cmd;
          touch_count_i   <= nxt.touches;
          pressed_count_i <= nxt.pressed;
          first_x_i       <= nxt.fx;
          first_y_i       <= nxt.fy;
          pressed_x_i     <= nxt.px;
          pressed_y_i     <= nxt.py;
          inside_region_i <= nxt.in_region;
          in_valid_i      <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode, mode_left, run_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode = STALL_NONE;
      mode_left  = 0;
      run_left   = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      unique case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: begin
          if (run_left > 0) begin
            run_left--;
          end else begin
            out_stall_i <= !out_stall_i;
            run_left = out_stall_i ? $urandom_range(1, 8) : $urandom_range(1, 30);
          end
        end
      endcase
    end
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    gesture_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_res.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_res.pop_front();
        check_field("trigger", COORD_W'(trigger_o), COORD_W'(want.trig));
        check_field("drag_phase", COORD_W'(drag_phase_o), COORD_W'(want.phase));
        check_field("start_x", start_x_o, want.sx);
        check_field("start_y", start_y_o, want.sy);
        check_field("prev_x", prev_x_o, want.prx);
        check_field("prev_y", prev_y_o, want.pry);
        check_field("cur_x", cur_x_o, want.cx);
        check_field("cur_y", cur_y_o, want.cy);
      end
    end
  end

  // stimulus helpers
  task automatic add_evt(input logic [tdg_pkg::CMD_W-1:0] cmd, input int touches,
                         input int pressed, input int fx, input int fy, input int px,
                         input int py, input logic in_region);
    touch_evt_t ev;
    ev = '{cmd: cmd, touches: tdg_pkg::CNT_W'(touches), pressed: tdg_pkg::CNT_W'(pressed),
           fx: COORD_W'(fx), fy: COORD_W'(fy), px: COORD_W'(px), py: COORD_W'(py),
           in_region: in_region};
    evt_queue.push_back(ev);
    n_queued++;
  endtask

  function automatic int rand_coord();
    unique case ($urandom_range(0, 7))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic int rand_cnt();
    return $urandom_range(0, 10);
  endfunction

  function automatic int offset_coord(input int o, input int d);
    int v;
    v = ($urandom_range(0, 1) == 1) ? o + d : o - d;
    if (v < 0) v = o + d;
    if (v > COORD_MAX) v = (o - d >= 0) ? o - d : COORD_MAX;
    return v;
  endfunction

  // one arming event, up to six moves mostly around the start distance, then some ending
  task automatic add_gesture();
    int ox, oy, n_moves, lim, dx, dy, mx, my;
    ox = rand_coord();
    oy = rand_coord();
    if ($urandom_range(0, 9) == 0)
      add_evt(tdg_pkg::CMD_PUP, $urandom_range(1, 10), 1, rand_coord(), rand_coord(),
              ox, oy, 1'b1);
    else
      add_evt(tdg_pkg::CMD_DOWN, 1, rand_cnt(), ox, oy, rand_coord(), rand_coord(), 1'b1);
    n_moves = $urandom_range(0, 6);
    for (int i = 0; i < n_moves; i++) begin
      if ($urandom_range(0, 2) != 0) begin
        lim = int'(thresh) + 1;
        dx  = $urandom_range(0, lim);
        dy  = $rtoi($sqrt(real'(lim * lim - dx * dx))) + int'($urandom_range(0, 2)) - 1;
        if (dy < 0) dy = 0;
        mx = offset_coord(ox, dx);
        my = offset_coord(oy, dy);
      end else begin
        mx = rand_coord();
        my = rand_coord();
      end
      add_evt(tdg_pkg::CMD_MOVE, ($urandom_range(0, 11) == 0) ? rand_cnt() : 1,
              rand_cnt(), mx, my, rand_coord(), rand_coord(), $urandom_range(0, 15) != 0);
    end
    // ending: any event kind, sometimes empty or outside the region
    add_evt(tdg_pkg::CMD_W'($urandom_range(tdg_pkg::CMD_DOWN, CMD_OTHER)),
            ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3), $urandom_range(0, 3),
            rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            $urandom_range(0, 7) != 0);
  endtask

  task automatic run_random(input int n_items);
    int first;
    @(negedge clk_i);
    first = n_queued;
    while (n_queued - first < n_items) begin
      if ($urandom_range(0, 6) == 0)
        add_evt(tdg_pkg::CMD_W'($urandom_range(tdg_pkg::CMD_DOWN, CMD_OTHER)), rand_cnt(),
                rand_cnt(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(0, 1));
      else
        add_gesture();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (evt_queue.size() != 0 || in_valid_i || expected_res.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tdg_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= tdg_pkg::CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tdg_pkg::CFG_IGNORE_MODE) ign_mode = val[0];
    else thresh = val[tdg_pkg::THRESH_W-1:0];
  endtask

  // a drag armed at one corner, optionally pulled to the far corner
  task automatic add_corner_drag(input logic pull);
    add_evt(tdg_pkg::CMD_DOWN, 1, 1, 0, 0, COORD_MAX, COORD_MAX, 1'b1);
    if (pull) add_evt(tdg_pkg::CMD_MOVE, 1, 1, COORD_MAX, COORD_MAX, 0, 0, 1'b1);
  endtask

  // timeout
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top NOT OK");
    $finish;
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset threshold of 16, so the start limit is 17 squared
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, 50, 50, 0, 0, 1'b1);                 // move while idle
    add_evt(tdg_pkg::CMD_DOWN, 1, 0, 100, 100, COORD_MAX, COORD_MAX, 1'b1); // arm
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, 116, 100, 0, 0, 1'b1);               // just short
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, 117, 100, 0, 0, 1'b1);               // exactly at limit
    add_evt(tdg_pkg::CMD_MOVE, 2, 2, 300, 300, 0, 0, 1'b1);               // two fingers
    add_evt(tdg_pkg::CMD_MOVE, 1, 1, COORD_MAX, 0, 0, 0, 1'b1);           // update
    add_evt(tdg_pkg::CMD_DOWN, 2, 2, 9, 9, 0, 0, 1'b1);                   // multi down
    add_evt(tdg_pkg::CMD_PUP, 3, 2, 9, 9, 5, 5, 1'b1);                    // two left
    add_evt(CMD_OTHER, 1, 1, 9, 9, 0, 0, 1'b1);
    add_evt(tdg_pkg::CMD_UP, 1, 0, COORD_MAX, COORD_MAX, 0, 0, 1'b1);     // release
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, 0, 0, 0, 0, 1'b1);                   // move, finished
    add_evt(tdg_pkg::CMD_UP, 1, 0, 3, 3, 0, 0, 1'b1);                     // up, finished
    add_evt(tdg_pkg::CMD_PUP, 2, 1, 7, 7, COORD_MAX, 0, 1'b1);            // re-arm
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, COORD_MAX, 16, 0, 0, 1'b0);          // leave region
    add_evt(tdg_pkg::CMD_DOWN, 10, 10, 1, 1, 1, 1, 1'b1);
    add_evt(tdg_pkg::CMD_DOWN, 1, 0, 0, 0, 0, 0, 1'b1);
    add_evt(tdg_pkg::CMD_PDOWN, 2, 2, 5, 5, 0, 0, 1'b1);                  // extra pointer
    add_evt(tdg_pkg::CMD_DOWN, 1, 0, 0, COORD_MAX, 0, 0, 1'b1);
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, COORD_MAX, 0, 0, 0, 1'b1);           // longest start
    add_evt(tdg_pkg::CMD_MOVE, 0, 0, 10, 10, 0, 0, 1'b1);                 // empty event
    add_evt(tdg_pkg::CMD_DOWN, 1, 0, 2000, 2000, 0, 0, 1'b1);
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, 2012, 2012, 0, 0, 1'b1);             // one short
    add_evt(tdg_pkg::CMD_MOVE, 1, 0, 2008, 2015, 0, 0, 1'b1);             // diagonal
    add_evt(tdg_pkg::CMD_PDOWN, 2, 2, 1, 2, 0, 0, 1'b1);                  // extra pointer
    add_corner_drag(1'b1);
    wait_drained();

    // ignore mode with a drag in progress
    write_reg(tdg_pkg::CFG_IGNORE_MODE, 1);
    write_reg(tdg_pkg::CFG_THRESHOLD, 40);
    run_random(40);
    wait_drained();

    // threshold extremes
    write_reg(tdg_pkg::CFG_IGNORE_MODE, 0);
    write_reg(tdg_pkg::CFG_THRESHOLD, 0);
    run_random(300);
    wait_drained();
    write_reg(tdg_pkg::CFG_THRESHOLD, (1 << tdg_pkg::THRESH_W) - 1);
    run_random(300);
    wait_drained();
    write_reg(tdg_pkg::CFG_THRESHOLD, $urandom_range(1, 64));
    run_random(400);
    add_corner_drag(1'b0);
    wait_drained();

    // ignore mode with a pending gesture
    write_reg(tdg_pkg::CFG_IGNORE_MODE, 1);
    write_reg(tdg_pkg::CFG_THRESHOLD, 100);
    run_random(60);
    wait_drained();

    write_reg(tdg_pkg::CFG_IGNORE_MODE, 0);
    write_reg(tdg_pkg::CFG_THRESHOLD, $urandom_range(0, 300));
    run_random(580);
    wait_drained();

    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/tdg_pkg.sv
design/tdg_dist.sv
design/tdg_core.sv
design/touch_drag_gesture_fsm.sv
tb/tb_top.sv
